/* hw/rtl/fkc_pkg.sv */
// ----------------------------------------------------------------------------
// fkc_pkg
// Shared types, widths and tables for the modified-DH forward kinematics block.
// ----------------------------------------------------------------------------
package fkc_pkg;

  localparam int MAX_JOINTS  = 8;
  localparam int ANGLE_BITS  = 16;
  localparam int LENGTH_BITS = 24;

  localparam int CNT_W   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int ROT_W   = 18;
  localparam int POS_W   = 32;
  localparam int PJ_W    = LENGTH_BITS + 3;
  localparam int PROD_W  = ROT_W + PJ_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int RND_W   = ACC_W - 16;
  localparam int SUM_W   = ((RND_W > POS_W) ? RND_W : POS_W) + 1;
  localparam int TURN_W  = 24;
  localparam int Z_W     = 26;
  localparam int XY_W    = 34;
  localparam int CORDIC_N = 16;
  localparam int IT_W    = 4;
  localparam int CORDIC_K = 652032874;
  localparam int ONE_Q16  = 65536;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0]  joint_twist;
    logic signed [LENGTH_BITS-1:0] link_length;
    logic signed [ANGLE_BITS-1:0]  theta_offset;
    logic signed [ANGLE_BITS-1:0]  joint_angle;
    logic signed [LENGTH_BITS-1:0] link_offset;
    logic                          last_joint;
  } fkc_in_t;

  typedef struct packed {
    logic [2:0]              joint_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    end_point;
  } fkc_out_t;

  // Angles reduced to a quadrant and a residual within an eighth turn
  typedef struct packed {
    logic [1:0]                    q_a;
    logic signed [TURN_W-1:0]      z_a;
    logic [1:0]                    q_t;
    logic signed [TURN_W-1:0]      z_t;
    logic signed [LENGTH_BITS-1:0] a;
    logic signed [LENGTH_BITS-1:0] d;
    logic                          last;
  } fkc_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CORDIC,
    BK_MAP,
    BK_JOINT,
    BK_MAT,
    BK_POS,
    BK_DONE
  } fkc_state_t;

  function automatic logic signed [Z_W-1:0] atan_val(input logic [IT_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      4'd0:    v = Z_W'(2097152);
      4'd1:    v = Z_W'(1238021);
      4'd2:    v = Z_W'(654136);
      4'd3:    v = Z_W'(332050);
      4'd4:    v = Z_W'(166669);
      4'd5:    v = Z_W'(83416);
      4'd6:    v = Z_W'(41718);
      4'd7:    v = Z_W'(20860);
      4'd8:    v = Z_W'(10430);
      4'd9:    v = Z_W'(5215);
      4'd10:   v = Z_W'(2608);
      4'd11:   v = Z_W'(1304);
      4'd12:   v = Z_W'(652);
      4'd13:   v = Z_W'(326);
      4'd14:   v = Z_W'(163);
      default: v = Z_W'(81);
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/fkc_front.sv */
// ----------------------------------------------------------------------------
// fkc_front
// Accepts joint items, forms the turn angles and reduces them to quadrants.
// ----------------------------------------------------------------------------
module fkc_front (
  input  fkc_pkg::fkc_in_t  item,
  input  logic              push,
  output logic              full,
  output fkc_pkg::fkc_job_t job,
  output logic              job_push,
  input  logic              job_full
);
  import fkc_pkg::*;

  localparam logic [TURN_W-1:0] EIGHTH = TURN_W'(24'h200000);

  logic [ANGLE_BITS-1:0] theta_sum;
  logic [TURN_W-1:0]     u_a;
  logic [TURN_W-1:0]     u_t;
  logic [TURN_W-1:0]     s_a;
  logic [TURN_W-1:0]     s_t;

  assign theta_sum = ANGLE_BITS'(item.theta_offset + item.joint_angle);
  assign u_a = TURN_W'(item.joint_twist) << (TURN_W - ANGLE_BITS);
  assign u_t = TURN_W'(theta_sum) << (TURN_W - ANGLE_BITS);
  assign s_a = u_a + EIGHTH;
  assign s_t = u_t + EIGHTH;

  always_comb begin
    job.q_a  = s_a[TURN_W-1:TURN_W-2];
    job.z_a  = u_a - {s_a[TURN_W-1:TURN_W-2], {(TURN_W-2){1'b0}}};
    job.q_t  = s_t[TURN_W-1:TURN_W-2];
    job.z_t  = u_t - {s_t[TURN_W-1:TURN_W-2], {(TURN_W-2){1'b0}}};
    job.a    = item.link_length;
    job.d    = item.link_offset;
    job.last = item.last_joint;
  end

  assign job_push = push;
  assign full     = job_full;

endmodule

/* hw/rtl/fkc_queue.sv */
// ----------------------------------------------------------------------------
// fkc_queue
// Two-entry queue of prepared joint jobs between front and back.
// ----------------------------------------------------------------------------
module fkc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  fkc_pkg::fkc_job_t din,
  input  logic              pop,
  output logic              empty,
  output fkc_pkg::fkc_job_t dout
);
  import fkc_pkg::*;

  fkc_job_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

/* hw/rtl/fkc_back.sv */
// ----------------------------------------------------------------------------
// fkc_back
// CORDIC sine/cosine, joint transform and chain product on one shared MAC,
// with the cumulative transform and a one-entry result register.
// ----------------------------------------------------------------------------
module fkc_back (
  input  logic              clk,
  input  logic              rst,
  input  fkc_pkg::fkc_job_t job,
  input  logic              job_empty,
  output logic              job_pop,
  output fkc_pkg::fkc_out_t result,
  output logic              empty,
  input  logic              pop
);
  import fkc_pkg::*;

  localparam int IDX_W = (CNT_W < 3) ? 3 : CNT_W;
  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(32768);
  localparam logic signed [XY_W-1:0]  XY_HALF = XY_W'(8192);
  localparam logic signed [RND_W-1:0] ROT_MAX = RND_W'((1 << (ROT_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] ROT_MIN = -ROT_MAX - RND_W'(1);
  localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);

  fkc_state_t state;
  fkc_state_t state_next;

  logic [IT_W-1:0]         it;
  logic signed [XY_W-1:0]  xa, ya, xt, yt;
  logic signed [Z_W-1:0]   za, zt;
  logic [1:0]              qa, qt;
  logic signed [LENGTH_BITS-1:0] jd;
  logic                    jlast;

  logic signed [ROT_W-1:0] ca, sa, ct, st;
  logic signed [ROT_W-1:0] rj [9];
  logic signed [PJ_W-1:0]  pj [3];
  logic signed [ROT_W-1:0] racc [9];
  logic signed [POS_W-1:0] tacc [3];
  logic signed [ROT_W-1:0] nr [9];
  logic signed [POS_W-1:0] np [3];
  logic [CNT_W-1:0]        cnt;

  logic [1:0]              ri, ci, ki;
  logic [2:0]              jstep;
  logic signed [ACC_W-1:0] acc;

  fkc_out_t                out_reg;
  logic                    out_valid;

  logic                    commit;
  logic                    chain_end;
  logic                    last_term;
  logic signed [ROT_W-1:0] opa;
  logic signed [PJ_W-1:0]  opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] sum_now;
  logic signed [ACC_W-1:0] rnd_full;
  logic signed [RND_W-1:0] rnd;
  logic signed [ROT_W-1:0] rot_sat;
  logic signed [SUM_W-1:0] psum;
  logic signed [POS_W-1:0] pos_sat;
  logic signed [XY_W-1:0]  cxa, cya, cxt, cyt;
  logic signed [ROT_W-1:0] m_ca, m_sa, m_ct, m_st;
  logic [IDX_W-1:0]        idx_ext;

  function automatic logic [3:0] ix(input logic [1:0] r, input logic [1:0] c);
    return 4'({2'b00, r} * 4'd3 + {2'b00, c});
  endfunction

  assign commit    = !out_valid || pop;
  assign chain_end = jlast || (cnt == CNT_W'(MAX_JOINTS - 1));
  assign idx_ext   = IDX_W'(cnt);
  assign result    = out_reg;
  assign empty     = !out_valid;

  // Quadrant mapping of the rounded CORDIC outputs
  assign cxa = (xa + XY_HALF) >>> 14;
  assign cya = (ya + XY_HALF) >>> 14;
  assign cxt = (xt + XY_HALF) >>> 14;
  assign cyt = (yt + XY_HALF) >>> 14;

  always_comb begin
    case (qa)
      2'd0:    begin m_ca = ROT_W'(cxa);  m_sa = ROT_W'(cya);  end
      2'd1:    begin m_ca = -ROT_W'(cya); m_sa = ROT_W'(cxa);  end
      2'd2:    begin m_ca = -ROT_W'(cxa); m_sa = -ROT_W'(cya); end
      default: begin m_ca = ROT_W'(cya);  m_sa = -ROT_W'(cxa); end
    endcase
    case (qt)
      2'd0:    begin m_ct = ROT_W'(cxt);  m_st = ROT_W'(cyt);  end
      2'd1:    begin m_ct = -ROT_W'(cyt); m_st = ROT_W'(cxt);  end
      2'd2:    begin m_ct = -ROT_W'(cxt); m_st = -ROT_W'(cyt); end
      default: begin m_ct = ROT_W'(cyt);  m_st = -ROT_W'(cxt); end
    endcase
  end

  // Shared multiply-accumulate
  always_comb begin
    opa       = '0;
    opb       = '0;
    last_term = 1'b0;
    case (state)
      BK_JOINT: begin
        last_term = 1'b1;
        case (jstep)
          3'd0:    begin opa = st; opb = PJ_W'(ca); end
          3'd1:    begin opa = ct; opb = PJ_W'(ca); end
          3'd2:    begin opa = st; opb = PJ_W'(sa); end
          3'd3:    begin opa = ct; opb = PJ_W'(sa); end
          3'd4:    begin opa = sa; opb = PJ_W'(jd); end
          default: begin opa = ca; opb = PJ_W'(jd); end
        endcase
      end
      BK_MAT: begin
        opa       = racc[ix(ri, ki)];
        opb       = PJ_W'(rj[ix(ki, ci)]);
        last_term = (ki == 2'd2);
      end
      BK_POS: begin
        opa       = racc[ix(ri, ci)];
        opb       = pj[ci];
        last_term = (ci == 2'd2);
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign prod     = opa * opb;
  assign sum_now  = acc + ACC_W'(prod);
  assign rnd_full = (sum_now + HALF) >>> 16;
  assign rnd      = RND_W'(rnd_full);
  assign rot_sat  = (rnd > ROT_MAX) ? ROT_W'(ROT_MAX) :
                    (rnd < ROT_MIN) ? ROT_W'(ROT_MIN) : ROT_W'(rnd);
  assign psum     = SUM_W'(rnd) + SUM_W'(tacc[ri]);
  assign pos_sat  = (psum > POS_MAX) ? POS_W'(POS_MAX) :
                    (psum < POS_MIN) ? POS_W'(POS_MIN) : POS_W'(psum);

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          state_next = BK_CORDIC;
        end
      end
      BK_CORDIC: begin
        if (it == IT_W'(CORDIC_N - 1)) begin
          state_next = BK_MAP;
        end
      end
      BK_MAP: begin
        state_next = BK_JOINT;
      end
      BK_JOINT: begin
        if (jstep == 3'd5) begin
          state_next = BK_MAT;
        end
      end
      BK_MAT: begin
        if (ri == 2'd2 && ci == 2'd2 && ki == 2'd2) begin
          state_next = BK_POS;
        end
      end
      BK_POS: begin
        if (ri == 2'd2 && ci == 2'd2) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (commit) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        qa    <= job.q_a;
        qt    <= job.q_t;
        za    <= Z_W'(job.z_a);
        zt    <= Z_W'(job.z_t);
        xa    <= XY_W'(CORDIC_K);
        xt    <= XY_W'(CORDIC_K);
        ya    <= '0;
        yt    <= '0;
        it    <= '0;
        pj[0] <= PJ_W'(job.a);
        jd    <= job.d;
        jlast <= job.last;
      end
      BK_CORDIC: begin
        if (!za[Z_W-1]) begin
          xa <= xa - (ya >>> it);
          ya <= ya + (xa >>> it);
          za <= za - atan_val(it);
        end else begin
          xa <= xa + (ya >>> it);
          ya <= ya - (xa >>> it);
          za <= za + atan_val(it);
        end
        if (!zt[Z_W-1]) begin
          xt <= xt - (yt >>> it);
          yt <= yt + (xt >>> it);
          zt <= zt - atan_val(it);
        end else begin
          xt <= xt + (yt >>> it);
          yt <= yt - (xt >>> it);
          zt <= zt + atan_val(it);
        end
        it <= it + IT_W'(1);
      end
      BK_MAP: begin
        ca    <= m_ca;
        sa    <= m_sa;
        ct    <= m_ct;
        st    <= m_st;
        rj[0] <= m_ct;
        rj[1] <= -m_st;
        rj[2] <= '0;
        rj[5] <= -m_sa;
        rj[8] <= m_ca;
        acc   <= '0;
        jstep <= '0;
        ri    <= '0;
        ci    <= '0;
        ki    <= '0;
      end
      BK_JOINT: begin
        case (jstep)
          3'd0:    rj[3] <= ROT_W'(rnd);
          3'd1:    rj[4] <= ROT_W'(rnd);
          3'd2:    rj[6] <= ROT_W'(rnd);
          3'd3:    rj[7] <= ROT_W'(rnd);
          3'd4:    pj[1] <= -PJ_W'(rnd);
          default: pj[2] <= PJ_W'(rnd);
        endcase
        jstep <= jstep + 3'd1;
      end
      BK_MAT: begin
        if (last_term) begin
          nr[ix(ri, ci)] <= rot_sat;
          acc <= '0;
          ki  <= '0;
          if (ci == 2'd2) begin
            ci <= '0;
            ri <= (ri == 2'd2) ? 2'd0 : ri + 2'd1;
          end else begin
            ci <= ci + 2'd1;
          end
        end else begin
          acc <= sum_now;
          ki  <= ki + 2'd1;
        end
      end
      BK_POS: begin
        if (last_term) begin
          np[ri] <= pos_sat;
          acc <= '0;
          ci  <= '0;
          ri  <= (ri == 2'd2) ? 2'd0 : ri + 2'd1;
        end else begin
          acc <= sum_now;
          ci  <= ci + 2'd1;
        end
      end
      default: begin
        if (commit) begin
          out_reg.joint_index <= idx_ext[2:0];
          out_reg.pos_x       <= np[0];
          out_reg.pos_y       <= np[1];
          out_reg.pos_z       <= np[2];
          out_reg.end_point   <= chain_end;
        end
      end
    endcase
  end

  // Kept transform, joint count and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        racc[i] <= (i % 4 == 0) ? ROT_W'(ONE_Q16) : '0;
      end
      for (int i = 0; i < 3; i++) begin
        tacc[i] <= '0;
      end
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == BK_DONE && commit) begin
        out_valid <= 1'b1;
        if (chain_end) begin
          for (int i = 0; i < 9; i++) begin
            racc[i] <= (i % 4 == 0) ? ROT_W'(ONE_Q16) : '0;
          end
          for (int i = 0; i < 3; i++) begin
            tacc[i] <= '0;
          end
          cnt <= '0;
        end else begin
          for (int i = 0; i < 9; i++) begin
            racc[i] <= nr[i];
          end
          for (int i = 0; i < 3; i++) begin
            tacc[i] <= np[i];
          end
          cnt <= cnt + CNT_W'(1);
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> (state == BK_IDLE && !job_empty))
    else $error("job taken outside idle");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DONE && commit) |=> (out_valid && state == BK_IDLE))
    else $error("commit did not post a result");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DONE && commit && chain_end) |=>
      (cnt == '0 && racc[0] == ROT_W'(ONE_Q16) && tacc[0] == '0))
    else $error("chain end did not reset the accumulator");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DONE && commit && !chain_end) |=> (cnt != '0))
    else $error("joint count did not advance");

endmodule

/* hw/rtl/mdh_forward_kinematics_chain.sv */
// ----------------------------------------------------------------------------
// mdh_forward_kinematics_chain
// Forward kinematics of a serial chain in modified Denavit-Hartenberg form.
// ----------------------------------------------------------------------------
// Input queue side: drive item and raise push; the joint transaction is taken
// on a clock edge where push is high and full is low. Each item is one joint;
// last_joint closes the chain (so does the MAX_JOINTS-th joint).
// Result queue side: while empty is low, result holds the frame origin of the
// oldest joint; raise pop to take it.
// In the back end each joint is fetched from the job queue, both angles run
// through 16 CORDIC iterations at once, the quadrants are mapped, then 42
// products run on the single shared multiply-accumulate (6 for the joint frame,
// 27 for the rotation product, 9 for the origin) and the result is posted.
// The back end works on one joint at a time. A two-entry job queue lets the
// front take items while the back is busy; the back starts the next joint
// while a result waits.
// If pop stays low the result register stays full, the back stops before
// updating its transform, the job queue fills and full rises.
// Reset (rst, synchronous) empties both queues, sets the kept transform to
// identity and the joint count to zero.
// ----------------------------------------------------------------------------
module mdh_forward_kinematics_chain (
  input  logic              clk,
  input  logic              rst,
  input  fkc_pkg::fkc_in_t  item,
  input  logic              push,
  output logic              full,
  output fkc_pkg::fkc_out_t result,
  output logic              empty,
  input  logic              pop
);
  import fkc_pkg::*;

  fkc_job_t fr_job;
  fkc_job_t q_job;
  logic     fr_push;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;

  fkc_front u_front (
    .item     (item),
    .push     (push),
    .full     (full),
    .job      (fr_job),
    .job_push (fr_push),
    .job_full (q_full)
  );

  fkc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fr_push),
    .full  (q_full),
    .din   (fr_job),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_job)
  );

  fkc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_job),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
